[rtl/msrt_pkg.sv]
package msrt_pkg;

  localparam int SLOT_COUNT = 4;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int MAX_OUT    = 4;
  localparam int EV_W       = $clog2(MAX_OUT + 1);
  localparam int TIME_W     = 32;
  localparam int MEM_W      = 2 * TIME_W;

  // floor(x / 1000) = (x * RECIP_1000) >> RECIP_SHIFT, exact for x <= 2^31
  localparam logic [31:0] RECIP_1000  = 32'd2199023256;
  localparam int          RECIP_SHIFT = 41;
  localparam logic [31:0] MS_PER_SEC  = 32'd1000;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_START    = 3'd1,
    OP_STOP     = 3'd2,
    OP_STOP_ALL = 3'd3,
    OP_CLEAR    = 3'd4,
    OP_QUERY    = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    BEEP_NONE  = 2'd0,
    BEEP_START = 2'd1,
    BEEP_END   = 2'd2,
    BEEP_WARN  = 2'd3
  } beep_e;

  typedef enum logic [1:0] {
    REG_WARN_THR = 2'd0,
    REG_WARN_INT = 2'd1,
    REG_DEF_DUR  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]  warn_threshold_sec;
    logic [15:0] warn_interval_ms;
    logic [15:0] default_duration_sec;
  } cfg_t;

  typedef struct packed {
    status_e             status;
    logic [SLOT_W-1:0]   slot;
    logic                active;
    logic [15:0]         remaining;
    beep_e               beep;
    logic                last;
  } res_t;

endpackage

[rtl/msrt_ram.sv]
module msrt_ram #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/msrt_div1000.sv]
module msrt_div1000 (
  input  logic        clk_i,
  input  logic [31:0] diff_i,
  output logic [15:0] quot_o
);

  localparam int Q_W = 64 - msrt_pkg::RECIP_SHIFT;

  logic [63:0]    prod_q;
  logic [Q_W-1:0] q_full;

  // registered reciprocal product, quotient derived combinationally from it
  always_ff @(posedge clk_i) begin
    prod_q <= {32'b0, diff_i} * {32'b0, msrt_pkg::RECIP_1000};
  end

  assign q_full = prod_q[63:msrt_pkg::RECIP_SHIFT];

  always_comb begin
    if (|q_full[Q_W-1:16]) begin
      quot_o = 16'hFFFF;
    end else begin
      quot_o = q_full[15:0];
    end
  end

endmodule

[rtl/msrt_cfg.sv]
module msrt_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output msrt_pkg::cfg_t      cfg_o
);

  msrt_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.warn_threshold_sec   <= 8'd30;
      cfg_q.warn_interval_ms     <= 16'd5000;
      cfg_q.default_duration_sec <= 16'd60;
    end else if (wr_en) begin
      unique case (reg_idx)
        msrt_pkg::REG_WARN_THR: cfg_q.warn_threshold_sec   <= pwdata[7:0];
        msrt_pkg::REG_WARN_INT: cfg_q.warn_interval_ms     <= pwdata[15:0];
        msrt_pkg::REG_DEF_DUR:  cfg_q.default_duration_sec <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      msrt_pkg::REG_WARN_THR: prdata = {24'b0, cfg_q.warn_threshold_sec};
      msrt_pkg::REG_WARN_INT: prdata = {16'b0, cfg_q.warn_interval_ms};
      msrt_pkg::REG_DEF_DUR:  prdata = {16'b0, cfg_q.default_duration_sec};
      default:                prdata = 32'b0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/multi_slot_relay_timer.sv]
// Bank of timed relay slots addressed by 32-bit machine keys.
// Input stream (s_axis): tuser carries the command, tdata the key and the
// duration in seconds. A tick command stands for one elapsed millisecond.
// Output stream (m_axis): one or more result items per defined op, tlast marks
// the final one. Tick commands give no item when no slot ends or warns.
// Config: APB-style registers at byte 0 (warning threshold, s), 4 (warning
// interval, ms) and 8 (default run time, s); pready is always high.
// Sequencing: commands run one at a time through a sequencer around a small
// slot-time memory with a registered read. Start, stop, stop-all and clear
// go straight from execution to the result; query does the same, or, when
// the slot is running, first passes a memory read and a reciprocal multiply
// for seconds. A tick scans every slot, giving each running slot a memory
// read and an end-or-warn decision, then delivers its results in slot order.
// The next command is accepted as soon as the last result sits in the
// output register, even while the receiver stalls; a stall holds the
// sequencer only when a further result must be written.
// Reset clears the slot map, all relays and the millisecond counter and
// loads the register defaults; no clearing pass is needed.
module multi_slot_relay_timer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // machine_key [31:0], duration_sec [47:32]
  input  logic [47:0] s_axis_tdata,
  // op [2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status [1:0], slot [3:2], relay_mask [7:4], slot_active [8],
  // remaining_sec [24:9], beep [26:25], zero [31:27]
  output logic [31:0] m_axis_tdata,
  // last_result
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int N  = msrt_pkg::SLOT_COUNT;
  localparam int SW = msrt_pkg::SLOT_W;
  localparam int CW = msrt_pkg::CNT_W;
  localparam int EW = msrt_pkg::EV_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_CALC,
    S_DEC,
    S_TEMIT,
    S_OUT
  } state_e;

  state_e              state_q;
  logic [2:0]          op_q;
  logic [31:0]         key_q;
  logic [15:0]         dur_q;
  logic [31:0]         now_q;
  logic [31:0]         key_arr_q [N];
  logic [N-1:0]        mapped_q;
  logic [N-1:0]        running_q;
  logic [CW-1:0]       idx_q;
  msrt_pkg::beep_e     ev_q [N];
  logic [15:0]         rem_arr_q [N];
  logic [EW-1:0]       ev_n_q;
  logic [EW-1:0]       emit_k_q;
  logic                expired_q;
  logic                gap_q;
  logic [31:0]         end_q;
  msrt_pkg::res_t      res_q;
  msrt_pkg::res_t      out_q;
  logic                out_valid_q;
  logic [3:0]          out_mask_q;

  msrt_pkg::cfg_t      cfg;
  logic [SW-1:0]       cur;
  logic                find_hit;
  logic [SW-1:0]       find_idx;
  logic                free_hit;
  logic [SW-1:0]       free_idx;
  logic                st_hit;
  logic [SW-1:0]       st_idx;
  logic [15:0]         dur_eff;
  logic [31:0]         end_new;
  logic                mem_we;
  logic [SW-1:0]       mem_waddr;
  logic [msrt_pkg::MEM_W-1:0] mem_wdata;
  logic [SW-1:0]       mem_raddr;
  logic [msrt_pkg::MEM_W-1:0] mem_rdata;
  logic [31:0]         rd_end;
  logic [31:0]         rd_lw;
  logic [31:0]         since_end;
  logic [31:0]         since_warn;
  logic [31:0]         diff;
  logic [15:0]         quot;
  logic [15:0]         rem_cur;
  logic                warn_cond;
  logic                is_query;
  logic                out_free;
  logic [N+3:0]        mask_ext;
  logic [3:0]          mask_now;
  logic [SW+1:0]       slot_ext;

  msrt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  msrt_ram #(
    .DEPTH (N),
    .WIDTH (msrt_pkg::MEM_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  msrt_div1000 u_div (
    .clk_i  (clk_i),
    .diff_i (diff),
    .quot_o (quot)
  );

  assign cur      = idx_q[SW-1:0];
  assign is_query = (op_q == msrt_pkg::OP_QUERY);

  // key lookup and first free slot
  always_comb begin
    find_hit = 1'b0;
    find_idx = '0;
    free_hit = 1'b0;
    free_idx = '0;
    if (key_q == 32'b0) begin
      find_hit = 1'b1;
    end else begin
      for (int i = 0; i < N; i++) begin
        if (!find_hit && mapped_q[i] && (key_arr_q[i] == key_q)) begin
          find_hit = 1'b1;
          find_idx = SW'(i);
        end
      end
    end
    for (int i = 0; i < N; i++) begin
      if (!free_hit && !mapped_q[i]) begin
        free_hit = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  assign st_hit  = find_hit || free_hit;
  assign st_idx  = find_hit ? find_idx : free_idx;
  assign dur_eff = (dur_q == 16'b0) ? cfg.default_duration_sec : dur_q;
  assign end_new = now_q + ({16'b0, dur_eff} * msrt_pkg::MS_PER_SEC);

  assign rd_end     = mem_rdata[63:32];
  assign rd_lw      = mem_rdata[31:0];
  assign since_end  = now_q - rd_end;
  assign since_warn = now_q - rd_lw;
  assign diff       = rd_end - now_q;

  assign rem_cur   = expired_q ? 16'b0 : quot;
  assign warn_cond = (rem_cur <= {8'b0, cfg.warn_threshold_sec}) && gap_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur;
    mem_wdata = {end_q, now_q};
    mem_raddr = cur;
    if (state_q == S_EXEC) begin
      mem_raddr = find_idx;
      if ((op_q == msrt_pkg::OP_START) && st_hit) begin
        mem_we    = 1'b1;
        mem_waddr = st_idx;
        mem_wdata = {end_new, 32'b0};
      end
    end else if ((state_q == S_DEC) && !is_query && !expired_q && warn_cond) begin
      mem_we = 1'b1;
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;
  assign mask_ext = {4'b0, running_q};
  assign mask_now = mask_ext[3:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= '0;
      key_q       <= '0;
      dur_q       <= '0;
      now_q       <= '0;
      mapped_q    <= '0;
      running_q   <= '0;
      idx_q       <= '0;
      ev_n_q      <= '0;
      emit_k_q    <= '0;
      expired_q   <= 1'b0;
      gap_q       <= 1'b0;
      end_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      out_mask_q  <= '0;
      for (int i = 0; i < N; i++) begin
        key_arr_q[i] <= '0;
        ev_q[i]      <= msrt_pkg::BEEP_NONE;
        rem_arr_q[i] <= '0;
      end
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_q    <= s_axis_tuser;
            key_q   <= s_axis_tdata[31:0];
            dur_q   <= s_axis_tdata[47:32];
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_q.status    <= msrt_pkg::ST_OK;
          res_q.slot      <= '0;
          res_q.active    <= 1'b0;
          res_q.remaining <= '0;
          res_q.beep      <= msrt_pkg::BEEP_NONE;
          res_q.last      <= 1'b1;
          state_q         <= S_OUT;
          unique case (op_q)
            msrt_pkg::OP_TICK: begin
              now_q   <= now_q + 32'd1;
              idx_q   <= '0;
              ev_n_q  <= '0;
              for (int i = 0; i < N; i++) begin
                ev_q[i] <= msrt_pkg::BEEP_NONE;
              end
              state_q <= S_SCAN;
            end
            msrt_pkg::OP_START: begin
              if (st_hit) begin
                if (!find_hit) begin
                  mapped_q[free_idx]  <= 1'b1;
                  key_arr_q[free_idx] <= key_q;
                end
                running_q[st_idx] <= 1'b1;
                res_q.slot        <= st_idx;
                res_q.active      <= 1'b1;
                res_q.remaining   <= dur_eff;
                res_q.beep        <= msrt_pkg::BEEP_START;
              end else begin
                res_q.status <= msrt_pkg::ST_NO_FREE;
              end
            end
            msrt_pkg::OP_STOP: begin
              if (find_hit) begin
                running_q[find_idx] <= 1'b0;
                res_q.slot          <= find_idx;
              end else begin
                res_q.status <= msrt_pkg::ST_NOT_FOUND;
              end
            end
            msrt_pkg::OP_STOP_ALL: begin
              running_q <= '0;
            end
            msrt_pkg::OP_CLEAR: begin
              running_q <= '0;
              mapped_q  <= '0;
              for (int i = 0; i < N; i++) begin
                key_arr_q[i] <= '0;
              end
            end
            msrt_pkg::OP_QUERY: begin
              if (find_hit) begin
                idx_q        <= CW'(find_idx);
                res_q.slot   <= find_idx;
                res_q.active <= running_q[find_idx];
                if (running_q[find_idx]) begin
                  state_q <= S_CALC;
                end
              end else begin
                res_q.status <= msrt_pkg::ST_NOT_FOUND;
              end
            end
            default: begin
              state_q <= S_IDLE;
            end
          endcase
        end
        S_SCAN: begin
          if ((idx_q == CW'(N)) || (ev_n_q == EW'(msrt_pkg::MAX_OUT))) begin
            idx_q    <= '0;
            emit_k_q <= '0;
            state_q  <= (ev_n_q == '0) ? S_IDLE : S_TEMIT;
          end else if (!running_q[cur]) begin
            idx_q <= idx_q + 1'b1;
          end else begin
            state_q <= S_CALC;
          end
        end
        S_CALC: begin
          expired_q <= !since_end[31];
          gap_q     <= since_warn > {16'b0, cfg.warn_interval_ms};
          end_q     <= rd_end;
          state_q   <= S_DEC;
        end
        S_DEC: begin
          if (is_query) begin
            res_q.remaining <= rem_cur;
            state_q         <= S_OUT;
          end else begin
            if (expired_q) begin
              running_q[cur] <= 1'b0;
              ev_q[cur]      <= msrt_pkg::BEEP_END;
              rem_arr_q[cur] <= '0;
              ev_n_q         <= ev_n_q + 1'b1;
            end else if (warn_cond) begin
              ev_q[cur]      <= msrt_pkg::BEEP_WARN;
              rem_arr_q[cur] <= rem_cur;
              ev_n_q         <= ev_n_q + 1'b1;
            end
            idx_q   <= idx_q + 1'b1;
            state_q <= S_SCAN;
          end
        end
        S_TEMIT: begin
          if (ev_q[cur] == msrt_pkg::BEEP_NONE) begin
            idx_q <= idx_q + 1'b1;
          end else if (out_free) begin
            out_valid_q     <= 1'b1;
            out_q.status    <= msrt_pkg::ST_OK;
            out_q.slot      <= cur;
            out_q.active    <= running_q[cur];
            out_q.remaining <= rem_arr_q[cur];
            out_q.beep      <= ev_q[cur];
            out_q.last      <= ((emit_k_q + 1'b1) == ev_n_q);
            out_mask_q      <= mask_now;
            emit_k_q        <= emit_k_q + 1'b1;
            idx_q           <= idx_q + 1'b1;
            if ((emit_k_q + 1'b1) == ev_n_q) begin
              state_q <= S_IDLE;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_q       <= res_q;
            out_mask_q  <= mask_now;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign slot_ext      = {2'b00, out_q.slot};
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {5'b0, out_q.beep, out_q.remaining, out_q.active,
                          out_mask_q, slot_ext[1:0], out_q.status};

  a_end_is_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_q.beep == msrt_pkg::BEEP_END)) |->
      (!out_q.active && (out_q.remaining == 16'b0)))
    else $error("end beep reported on a running slot");

  a_warn_is_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_q.beep == msrt_pkg::BEEP_WARN)) |-> out_q.active)
    else $error("warning beep reported on an idle slot");

  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TEMIT) |->
      ((emit_k_q < ev_n_q) && (ev_n_q <= EW'(msrt_pkg::MAX_OUT))))
    else $error("tick result count out of range");

  a_scan_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CALC) |-> running_q[cur])
    else $error("slot time read for an idle slot");

endmodule
